FILE: design/vt52a_pkg.sv
// shared types, byte codes and the microcode rom for the vt52 to ansi translator
// used by vt52a_useq and vt52_to_ansi_escape_translator_unit, no dependencies
package vt52a_pkg;

  localparam int UADDR_W = 7;
  typedef logic [UADDR_W-1:0] uaddr_t;

  localparam logic [7:0] BYTE_ESC = 8'h1b;
  localparam logic [7:0] BYTE_CR  = 8'h0d;
  localparam logic [7:0] CMD_FG   = 8'h62;  // b
  localparam logic [7:0] CMD_BG   = 8'h63;  // c
  localparam logic [7:0] CMD_POS  = 8'h59;  // Y

  typedef enum logic [1:0] {SRC_LIT, SRC_IN, SRC_DIGIT} src_t;
  typedef enum logic [1:0] {OP_NEXT, OP_END, OP_JMP, OP_BRF} op_t;

  typedef struct packed {
    src_t          src;
    op_t           op;
    logic [7:0]    lit;
    uaddr_t        target;
  } ucode_t;

  typedef struct packed {
    logic          go;
    uaddr_t        addr;
    logic [7:0]    arg;
    logic          flag;
  } seq_start_t;

  typedef struct packed {
    logic          hit;
    uaddr_t        addr;
  } entry_t;

  // program entry points
  localparam uaddr_t UA_ECHO  = 7'd0;
  localparam uaddr_t UA_UP    = 7'd1;
  localparam uaddr_t UA_DOWN  = 7'd4;
  localparam uaddr_t UA_RIGHT = 7'd7;
  localparam uaddr_t UA_LEFT  = 7'd10;
  localparam uaddr_t UA_CLEAR = 7'd13;
  localparam uaddr_t UA_HOME  = 7'd20;
  localparam uaddr_t UA_EOS   = 7'd23;
  localparam uaddr_t UA_EOL   = 7'd26;
  localparam uaddr_t UA_BOS   = 7'd29;
  localparam uaddr_t UA_CUR_ON  = 7'd33;
  localparam uaddr_t UA_CUR_OFF = 7'd39;
  localparam uaddr_t UA_SAVE  = 7'd45;
  localparam uaddr_t UA_REST  = 7'd48;
  localparam uaddr_t UA_LINE  = 7'd51;
  localparam uaddr_t UA_BOL   = 7'd59;
  localparam uaddr_t UA_REV   = 7'd63;
  localparam uaddr_t UA_NORM  = 7'd67;
  localparam uaddr_t UA_COLOR = 7'd72;
  localparam uaddr_t UA_COLOR_BG    = 7'd75;
  localparam uaddr_t UA_COLOR_DIGIT = 7'd76;

  function automatic ucode_t uw(logic [7:0] b, op_t op);
    ucode_t w;
    w.src    = SRC_LIT;
    w.op     = op;
    w.lit    = b;
    w.target = '0;
    return w;
  endfunction

  function automatic ucode_t rom(uaddr_t a);
    ucode_t w;
    case (a)
      7'd0: begin
        w = uw(8'h00, OP_END);
        w.src = SRC_IN;
      end
      7'd1:  w = uw(BYTE_ESC, OP_NEXT);
      7'd2:  w = uw("[", OP_NEXT);
      7'd3:  w = uw("A", OP_END);
      7'd4:  w = uw(BYTE_ESC, OP_NEXT);
      7'd5:  w = uw("[", OP_NEXT);
      7'd6:  w = uw("B", OP_END);
      7'd7:  w = uw(BYTE_ESC, OP_NEXT);
      7'd8:  w = uw("[", OP_NEXT);
      7'd9:  w = uw("C", OP_END);
      7'd10: w = uw(BYTE_ESC, OP_NEXT);
      7'd11: w = uw("[", OP_NEXT);
      7'd12: w = uw("D", OP_END);
      7'd13: w = uw(BYTE_ESC, OP_NEXT);
      7'd14: w = uw("[", OP_NEXT);
      7'd15: w = uw("H", OP_NEXT);
      7'd16: w = uw(BYTE_ESC, OP_NEXT);
      7'd17: w = uw("[", OP_NEXT);
      7'd18: w = uw("2", OP_NEXT);
      7'd19: w = uw("J", OP_END);
      7'd20: w = uw(BYTE_ESC, OP_NEXT);
      7'd21: w = uw("[", OP_NEXT);
      7'd22: w = uw("H", OP_END);
      7'd23: w = uw(BYTE_ESC, OP_NEXT);
      7'd24: w = uw("[", OP_NEXT);
      7'd25: w = uw("J", OP_END);
      7'd26: w = uw(BYTE_ESC, OP_NEXT);
      7'd27: w = uw("[", OP_NEXT);
      7'd28: w = uw("K", OP_END);
      7'd29: w = uw(BYTE_ESC, OP_NEXT);
      7'd30: w = uw("[", OP_NEXT);
      7'd31: w = uw("1", OP_NEXT);
      7'd32: w = uw("J", OP_END);
      7'd33: w = uw(BYTE_ESC, OP_NEXT);
      7'd34: w = uw("[", OP_NEXT);
      7'd35: w = uw("?", OP_NEXT);
      7'd36: w = uw("2", OP_NEXT);
      7'd37: w = uw("5", OP_NEXT);
      7'd38: w = uw("h", OP_END);
      7'd39: w = uw(BYTE_ESC, OP_NEXT);
      7'd40: w = uw("[", OP_NEXT);
      7'd41: w = uw("?", OP_NEXT);
      7'd42: w = uw("2", OP_NEXT);
      7'd43: w = uw("5", OP_NEXT);
      7'd44: w = uw("l", OP_END);
      7'd45: w = uw(BYTE_ESC, OP_NEXT);
      7'd46: w = uw("[", OP_NEXT);
      7'd47: w = uw("s", OP_END);
      7'd48: w = uw(BYTE_ESC, OP_NEXT);
      7'd49: w = uw("[", OP_NEXT);
      7'd50: w = uw("u", OP_END);
      7'd51: w = uw(BYTE_ESC, OP_NEXT);
      7'd52: w = uw("[", OP_NEXT);
      7'd53: w = uw("2", OP_NEXT);
      7'd54: w = uw("K", OP_NEXT);
      7'd55: w = uw(BYTE_ESC, OP_NEXT);
      7'd56: w = uw("[", OP_NEXT);
      7'd57: w = uw("1", OP_NEXT);
      7'd58: w = uw("G", OP_END);
      7'd59: w = uw(BYTE_ESC, OP_NEXT);
      7'd60: w = uw("[", OP_NEXT);
      7'd61: w = uw("1", OP_NEXT);
      7'd62: w = uw("K", OP_END);
      7'd63: w = uw(BYTE_ESC, OP_NEXT);
      7'd64: w = uw("[", OP_NEXT);
      7'd65: w = uw("7", OP_NEXT);
      7'd66: w = uw("m", OP_END);
      7'd67: w = uw(BYTE_ESC, OP_NEXT);
      7'd68: w = uw("[", OP_NEXT);
      7'd69: w = uw("2", OP_NEXT);
      7'd70: w = uw("7", OP_NEXT);
      7'd71: w = uw("m", OP_END);
      // color: flag selects background
      7'd72: w = uw(BYTE_ESC, OP_NEXT);
      7'd73: begin
        w = uw("[", OP_BRF);
        w.target = UA_COLOR_BG;
      end
      7'd74: begin
        w = uw("3", OP_JMP);
        w.target = UA_COLOR_DIGIT;
      end
      7'd75: w = uw("4", OP_NEXT);
      7'd76: begin
        w = uw("0", OP_NEXT);
        w.src = SRC_DIGIT;
      end
      7'd77: w = uw("m", OP_END);
      default: w = uw(8'h00, OP_END);
    endcase
    return w;
  endfunction

  // command letter to program entry, no hit for silent or unknown letters
  function automatic entry_t entry_of(logic [7:0] c);
    entry_t e;
    e.hit = 1'b1;
    case (c)
      "A":     e.addr = UA_UP;
      "B":     e.addr = UA_DOWN;
      "C":     e.addr = UA_RIGHT;
      "D":     e.addr = UA_LEFT;
      "E":     e.addr = UA_CLEAR;
      "H":     e.addr = UA_HOME;
      "I":     e.addr = UA_UP;
      "J":     e.addr = UA_EOS;
      "K":     e.addr = UA_EOL;
      "d":     e.addr = UA_BOS;
      "e":     e.addr = UA_CUR_ON;
      "f":     e.addr = UA_CUR_OFF;
      "j":     e.addr = UA_SAVE;
      "k":     e.addr = UA_REST;
      "l":     e.addr = UA_LINE;
      "o":     e.addr = UA_BOL;
      "p":     e.addr = UA_REV;
      "q":     e.addr = UA_NORM;
      default: begin
        e.hit  = 1'b0;
        e.addr = UA_ECHO;
      end
    endcase
    return e;
  endfunction

endpackage

FILE: design/vt52a_useq.sv
// microcode sequencer: steps through the rom and emits one output beat per step
// depends on vt52a_pkg (control word, start struct, rom function)
module vt52a_useq (
  input  logic                   clk,
  input  logic                   rst,
  input  vt52a_pkg::seq_start_t  start,
  output logic                   busy,
  output logic                   m_axis_tvalid,
  input  logic                   m_axis_tready,
  output logic [7:0]             m_axis_tdata,   // [7:0] out_byte
  output logic                   m_axis_tlast    // last_byte
);

  vt52a_pkg::uaddr_t step;
  vt52a_pkg::uaddr_t step_next;
  logic [7:0]        arg;
  logic              flag;
  vt52a_pkg::ucode_t word;
  logic [7:0]        byte_out;
  logic              adv;

  assign word = vt52a_pkg::rom(step);
  assign adv  = busy && (!m_axis_tvalid || m_axis_tready);

  always_comb begin
    case (word.src)
      vt52a_pkg::SRC_IN:    byte_out = arg;
      vt52a_pkg::SRC_DIGIT: byte_out = {5'b00110, arg[2:0]};
      default:              byte_out = word.lit;
    endcase
  end

  always_comb begin
    case (word.op)
      vt52a_pkg::OP_JMP: step_next = word.target;
      vt52a_pkg::OP_BRF: step_next = flag ? word.target : step + vt52a_pkg::uaddr_t'(1);
      vt52a_pkg::OP_END: step_next = step;
      default:           step_next = step + vt52a_pkg::uaddr_t'(1);
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy          <= 1'b0;
      m_axis_tvalid <= 1'b0;
    end else begin
      if (start.go) begin
        busy <= 1'b1;
        step <= start.addr;
        arg  <= start.arg;
        flag <= start.flag;
      end else if (adv) begin
        step <= step_next;
        if (word.op == vt52a_pkg::OP_END) begin
          busy <= 1'b0;
        end
      end
      if (adv) begin
        m_axis_tvalid <= 1'b1;
        m_axis_tdata  <= byte_out;
        m_axis_tlast  <= (word.op == vt52a_pkg::OP_END);
      end else if (m_axis_tready) begin
        m_axis_tvalid <= 1'b0;
      end
    end
  end

`ifndef ASSERT_OFF
  a_start_idle: assert property (@(posedge clk) disable iff (rst)
    start.go |-> !busy)
    else $error("program started while sequencer busy");

  a_end_frees: assert property (@(posedge clk) disable iff (rst)
    (adv && word.op == vt52a_pkg::OP_END) |=> !busy)
    else $error("sequencer still busy after end step");

  a_idle_last: assert property (@(posedge clk) disable iff (rst)
    (m_axis_tvalid && !busy) |-> m_axis_tlast)
    else $error("held beat without busy sequencer is not marked last");
`endif

endmodule

FILE: design/vt52_to_ansi_escape_translator_unit.sv
// top level of the vt52 to ansi escape translator: escape parser and config register
// depends on vt52a_pkg and vt52a_useq
//
// Takes one terminal byte per input beat and emits its ansi translation as
// 0 to 8 output beats, tlast on the final one. A byte that emits output holds
// the input until the microcode sequencer, which sets the rate, has issued its
// last byte; it reads one control word and emits one byte per step, stalling
// while the output stalls. Bytes that emit nothing (cr, esc, silent commands,
// arguments of Y) do not hold the input. The user must write passthrough_mode
// through cfg_we/cfg_wdata only while idle; the block does not enforce it.
module vt52_to_ansi_escape_translator_unit (
  input  logic       clk,
  input  logic       rst,
  input  logic       cfg_we,
  input  logic       cfg_wdata,      // passthrough_mode
  input  logic       s_axis_tvalid,
  output logic       s_axis_tready,
  input  logic [7:0] s_axis_tdata,   // [7:0] in_byte
  output logic       m_axis_tvalid,
  input  logic       m_axis_tready,
  output logic [7:0] m_axis_tdata,   // [7:0] out_byte
  output logic       m_axis_tlast    // last_byte
);

  typedef enum logic [1:0] {ST_NORMAL, ST_ESCAPED, ST_ARGUMENT, ST_COLUMN} parse_t;

  parse_t                 state;
  parse_t                 state_next;
  logic [7:0]             pending;
  logic [7:0]             pending_next;
  logic                   passthrough_mode;
  logic                   busy;
  logic                   acc;
  logic                   go;
  vt52a_pkg::entry_t      ent;
  vt52a_pkg::seq_start_t  start;

  assign s_axis_tready = !busy;
  assign acc           = s_axis_tvalid && s_axis_tready;
  assign ent           = vt52a_pkg::entry_of(s_axis_tdata);

  always_comb begin
    state_next   = state;
    pending_next = pending;
    go           = 1'b0;
    start.addr   = vt52a_pkg::UA_ECHO;
    start.arg    = s_axis_tdata;
    start.flag   = 1'b0;
    if (passthrough_mode) begin
      go = 1'b1;
    end else begin
      case (state)
        ST_NORMAL: begin
          if (s_axis_tdata == vt52a_pkg::BYTE_ESC) begin
            state_next = ST_ESCAPED;
          end else if (s_axis_tdata != vt52a_pkg::BYTE_CR) begin
            go = 1'b1;
          end
        end
        ST_ESCAPED: begin
          pending_next = s_axis_tdata;
          if (s_axis_tdata inside {vt52a_pkg::CMD_FG, vt52a_pkg::CMD_BG,
                                   vt52a_pkg::CMD_POS}) begin
            state_next = ST_ARGUMENT;
          end else begin
            state_next = ST_NORMAL;
            go         = ent.hit;
            start.addr = ent.addr;
          end
        end
        ST_ARGUMENT: begin
          pending_next = s_axis_tdata;
          state_next   = ST_NORMAL;
          if (pending == vt52a_pkg::CMD_POS) begin
            state_next = ST_COLUMN;
          end else if (pending inside {vt52a_pkg::CMD_FG, vt52a_pkg::CMD_BG}) begin
            go         = 1'b1;
            start.addr = vt52a_pkg::UA_COLOR;
            start.flag = (pending == vt52a_pkg::CMD_BG);
          end
        end
        default: state_next = ST_NORMAL;
      endcase
    end
    start.go = acc && go;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state            <= ST_NORMAL;
      pending          <= '0;
      passthrough_mode <= 1'b0;
    end else begin
      if (cfg_we) begin
        passthrough_mode <= cfg_wdata;
      end
      if (acc && !passthrough_mode) begin
        state   <= state_next;
        pending <= pending_next;
      end
    end
  end

  vt52a_useq u_seq (
    .clk           (clk),
    .rst           (rst),
    .start         (start),
    .busy          (busy),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast)
  );

`ifndef ASSERT_OFF
  a_pass_keeps_state: assert property (@(posedge clk) disable iff (rst)
    (acc && passthrough_mode) |=> $stable(state) && $stable(pending))
    else $error("passthrough beat changed parser state");

  a_column_done: assert property (@(posedge clk) disable iff (rst)
    (acc && !passthrough_mode && state == ST_COLUMN) |=> state == ST_NORMAL)
    else $error("parser did not return to normal after column byte");

  a_pos_to_column: assert property (@(posedge clk) disable iff (rst)
    (acc && !passthrough_mode && state == ST_ARGUMENT && pending == vt52a_pkg::CMD_POS)
      |=> state == ST_COLUMN && !busy)
    else $error("row byte of cursor position mishandled");
`endif

endmodule

FILE: tb/tb_top.sv
// self-checking testbench for vt52_to_ansi_escape_translator_unit
// predicts the ansi byte stream for each accepted input beat and checks the output beats
// depends on vt52a_pkg and the design files
module tb_top;

  typedef enum logic [1:0] {PST_NORMAL, PST_ESC, PST_ARG, PST_COL} vt_parse_t;

  typedef struct {
    logic [7:0] data;
    logic       last;
  } ansi_beat_t;

  localparam int CYCLE_LIMIT = 200000;
  localparam int DRAIN_CYCLES = 20;
  localparam int RX_HOLD_CYCLES = 250;
  localparam int RX_HOLD_AT = 80;

  logic       clk;
  logic       rst = 1'b1;
  logic       cfg_we = 1'b0;
  logic       cfg_wdata = 1'b0;
  logic       s_valid = 1'b0;
  logic [7:0] s_data = 8'h00;
  logic       s_axis_tready;
  logic       m_axis_tvalid;
  logic       m_ready = 1'b0;
  logic [7:0] m_axis_tdata;
  logic       m_axis_tlast;

  // predictor state
  logic       passthru = 1'b0;
  vt_parse_t  parse_st = PST_NORMAL;
  logic [7:0] esc_cmd = 8'h00;

  logic [7:0] bytes_to_send[$];
  ansi_beat_t ansi_expected[$];
  int         mismatch_count = 0;
  int         beats_seen = 0;
  int         cycle_count = 0;
  int         send_gap_pct = 0;
  int         recv_gap_pct = 0;
  int         rx_hold_left = 0;
  logic       rx_hold_done = 1'b0;

  string known_letters = "ABCDEHIJKdefjklopq";
  string silent_letters = "LMvw";

  logic [7:0] directed_bytes [25] = '{
    8'h00, 8'hff, vt52a_pkg::BYTE_CR,
    vt52a_pkg::BYTE_ESC, "E", vt52a_pkg::BYTE_ESC, "l", vt52a_pkg::BYTE_ESC, "L",
    vt52a_pkg::BYTE_ESC, vt52a_pkg::BYTE_ESC,
    vt52a_pkg::BYTE_ESC, vt52a_pkg::CMD_FG, 8'hff,
    vt52a_pkg::BYTE_ESC, vt52a_pkg::CMD_BG, 8'h00,
    vt52a_pkg::BYTE_ESC, vt52a_pkg::CMD_FG, vt52a_pkg::BYTE_ESC,
    vt52a_pkg::BYTE_ESC, vt52a_pkg::CMD_POS, vt52a_pkg::BYTE_CR, vt52a_pkg::BYTE_ESC,
    "A"
  };

  vt52_to_ansi_escape_translator_unit uut (
    .clk           (clk),
    .rst           (rst),
    .cfg_we        (cfg_we),
    .cfg_wdata     (cfg_wdata),
    .s_axis_tvalid (s_valid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_data),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_ready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  function automatic string ansi_tail(input logic [7:0] letter);
    case (letter)
      "A", "I": return "[A";
      "B":      return "[B";
      "C":      return "[C";
      "D":      return "[D";
      "E":      return "[H\033[2J";
      "H":      return "[H";
      "J":      return "[J";
      "K":      return "[K";
      "d":      return "[1J";
      "e":      return "[?25h";
      "f":      return "[?25l";
      "j":      return "[s";
      "k":      return "[u";
      "l":      return "[2K\033[1G";
      "o":      return "[1K";
      "p":      return "[7m";
      "q":      return "[27m";
      default:  return "";
    endcase
  endfunction

  task automatic push_beat(input logic [7:0] data, input logic last);
    ansi_beat_t b;
    b.data = data;
    b.last = last;
    ansi_expected.push_back(b);
  endtask

  // esc followed by the tail, nothing at all for an empty tail
  task automatic emit_ansi(input string tail);
    if (tail.len() != 0) begin
      push_beat(vt52a_pkg::BYTE_ESC, 1'b0);
      for (int i = 0; i < tail.len(); i++)
        push_beat(tail[i], i == tail.len() - 1);
    end
  endtask

  task automatic translate_byte(input logic [7:0] c);
    logic [7:0] cmd;
    string      color;
    if (passthru) begin
      push_beat(c, 1'b1);
    end else begin
      case (parse_st)
        PST_NORMAL: begin
          if (c == vt52a_pkg::BYTE_ESC)
            parse_st = PST_ESC;
          else if (c != vt52a_pkg::BYTE_CR)
            push_beat(c, 1'b1);
        end
        PST_ESC: begin
          esc_cmd = c;
          if (c == vt52a_pkg::CMD_FG || c == vt52a_pkg::CMD_BG || c == vt52a_pkg::CMD_POS) begin
            parse_st = PST_ARG;
          end else begin
            parse_st = PST_NORMAL;
            emit_ansi(ansi_tail(c));
          end
        end
        PST_ARG: begin
          cmd = esc_cmd;
          esc_cmd = c;
          parse_st = PST_NORMAL;
          if (cmd == vt52a_pkg::CMD_POS) begin
            parse_st = PST_COL;
          end else if (cmd == vt52a_pkg::CMD_FG || cmd == vt52a_pkg::CMD_BG) begin
            color = (cmd == vt52a_pkg::CMD_FG) ? "[30m" : "[40m";
            color.putc(2, color[2] + {5'd0, c[2:0]});
            emit_ansi(color);
          end
        end
        default: parse_st = PST_NORMAL;
      endcase
    end
  endtask

  task automatic report_mismatch(input string what);
    $display("ERROR at beat %0d: %s", beats_seen, what);
    mismatch_count++;
  endtask

  task automatic check_beat(input logic [7:0] data, input logic last);
    ansi_beat_t want;
    if (ansi_expected.size() == 0) begin
      report_mismatch($sformatf("unexpected beat data %h last %b", data, last));
    end else begin
      want = ansi_expected.pop_front();
      if (data !== want.data)
        report_mismatch($sformatf("data got %h want %h", data, want.data));
      if (last !== want.last)
        report_mismatch($sformatf("tlast got %b want %b", last, want.last));
    end
    beats_seen++;
  endtask

  // sender: holds tdata until accepted, predicts on each accepted beat
  always @(posedge clk) begin
    if (rst) begin
      s_valid <= 1'b0;
      s_data <= 8'h00;
    end else begin
      if (s_valid && s_axis_tready)
        translate_byte(s_data);
      if (!s_valid || s_axis_tready) begin
        if (bytes_to_send.size() != 0 && $urandom_range(99) >= send_gap_pct) begin
          s_valid <= 1'b1;
          s_data <= bytes_to_send.pop_front();
        end else begin
          s_valid <= 1'b0;
        end
      end
    end
  end

  // receiver: random tready plus one long hold-off while the sender keeps pushing
  always @(posedge clk) begin
    if (rst) begin
      m_ready <= 1'b0;
    end else begin
      if (m_axis_tvalid && m_ready) begin
        check_beat(m_axis_tdata, m_axis_tlast);
        if (!rx_hold_done && beats_seen == RX_HOLD_AT) begin
          rx_hold_left = RX_HOLD_CYCLES;
          rx_hold_done = 1'b1;
        end
      end
      if (rx_hold_left > 0) begin
        rx_hold_left--;
        m_ready <= 1'b0;
      end else begin
        m_ready <= ($urandom_range(99) >= recv_gap_pct);
      end
    end
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("vt52_to_ansi_escape_translator_unit: mismatch");
      $finish;
    end
  end

  task automatic set_passthrough(input logic mode);
    @(posedge clk);
    cfg_we <= 1'b1;
    cfg_wdata <= mode;
    @(posedge clk);
    cfg_we <= 1'b0;
    passthru = mode;
  endtask

  // silent bytes can still be in flight after the last expected beat
  task automatic wait_drained();
    while (bytes_to_send.size() != 0 || s_valid || ansi_expected.size() != 0)
      @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);
  endtask

  function automatic logic [7:0] text_byte();
    logic [7:0] b;
    do b = 8'($urandom_range(255));
    while (b == vt52a_pkg::BYTE_ESC || b == vt52a_pkg::BYTE_CR);
    return b;
  endfunction

  task automatic queue_raw(input int count);
    repeat (count) bytes_to_send.push_back(8'($urandom_range(255)));
  endtask

  // mostly well-formed escape sequences with random content, some noise
  task automatic queue_traffic(input int count);
    int start;
    int kind;
    start = bytes_to_send.size();
    while (bytes_to_send.size() - start < count) begin
      kind = $urandom_range(9);
      case (kind)
        0, 1, 2: bytes_to_send.push_back(text_byte());
        3: bytes_to_send.push_back(vt52a_pkg::BYTE_CR);
        4, 5: begin
          bytes_to_send.push_back(vt52a_pkg::BYTE_ESC);
          bytes_to_send.push_back(known_letters[$urandom_range(known_letters.len() - 1)]);
        end
        6: begin
          bytes_to_send.push_back(vt52a_pkg::BYTE_ESC);
          bytes_to_send.push_back(silent_letters[$urandom_range(silent_letters.len() - 1)]);
        end
        7: begin
          bytes_to_send.push_back(vt52a_pkg::BYTE_ESC);
          bytes_to_send.push_back($urandom_range(1) ? vt52a_pkg::CMD_FG : vt52a_pkg::CMD_BG);
          bytes_to_send.push_back(8'($urandom_range(255)));
        end
        8: begin
          bytes_to_send.push_back(vt52a_pkg::BYTE_ESC);
          bytes_to_send.push_back(vt52a_pkg::CMD_POS);
          bytes_to_send.push_back(8'($urandom_range(255)));
          bytes_to_send.push_back(8'($urandom_range(255)));
        end
        default: begin
          // broken or odd sequence: esc then any byte
          bytes_to_send.push_back(vt52a_pkg::BYTE_ESC);
          bytes_to_send.push_back(8'($urandom_range(255)));
        end
      endcase
    end
  endtask

  initial begin
    repeat (10) @(posedge clk);
    rst <= 1'b0;
    set_passthrough(1'b0);

    send_gap_pct = 36;
    recv_gap_pct = 55;
    @(negedge clk);
    foreach (directed_bytes[i]) bytes_to_send.push_back(directed_bytes[i]);
    queue_traffic(120);
    // leave an escape open across the passthrough phase
    bytes_to_send.push_back(vt52a_pkg::BYTE_ESC);
    wait_drained();

    set_passthrough(1'b1);
    send_gap_pct = 55;
    recv_gap_pct = 36;
    @(negedge clk);
    queue_raw(60);
    wait_drained();

    set_passthrough(1'b0);
    @(negedge clk);
    queue_traffic(60);
    // color argument still pending when passthrough comes back on
    bytes_to_send.push_back(vt52a_pkg::BYTE_ESC);
    bytes_to_send.push_back(vt52a_pkg::CMD_FG);
    wait_drained();

    send_gap_pct = 0;
    recv_gap_pct = 0;
    set_passthrough(1'b1);
    @(negedge clk);
    queue_raw(20);
    wait_drained();

    set_passthrough(1'b0);
    @(negedge clk);
    queue_traffic(50);
    wait_drained();

    if (mismatch_count == 0)
      $display("vt52_to_ansi_escape_translator_unit: match");
    else
      $display("vt52_to_ansi_escape_translator_unit: mismatch");
    $finish;
  end

endmodule

FILE: vt52_to_ansi_escape_translator_unit.f
design/vt52a_pkg.sv
design/vt52a_useq.sv
design/vt52_to_ansi_escape_translator_unit.sv
tb/tb_top.sv
